FILE: src/sdc_pkg.sv
// Shared types, codes and constants of the disk controller host ports.
// No dependencies; every other file of the block but sdc_ram uses this package.
package sdc_pkg;

  // Fixed field widths
  localparam int BYTE_W         = 8;
  localparam int SECTOR_INDEX_W = 19;
  localparam int SEC_W          = 7;
  localparam int COUNT_W        = 7;
  localparam int CYL_W          = 12;
  localparam int HEAD_W         = 3;
  // Track number cyl*HEADS + head for up to eight heads
  localparam int TRK_W          = CYL_W + HEAD_W;

  // Item kinds
  typedef enum logic [1:0] {
    REQ_HOST_RD   = 2'd0,
    REQ_HOST_WR   = 2'd1,
    REQ_DISK_FILL = 2'd2,
    REQ_DISK_PULL = 2'd3
  } req_type_t;

  // Host port numbers
  localparam logic [2:0] PORT_CMD      = 3'd0;
  localparam logic [2:0] PORT_DATA     = 3'd1;
  localparam logic [2:0] PORT_RES0     = 3'd2;
  localparam logic [2:0] PORT_HEAD_CYL = 3'd3;
  localparam logic [2:0] PORT_CYL_LO   = 3'd4;
  localparam logic [2:0] PORT_SECTOR   = 3'd5;
  localparam logic [2:0] PORT_COUNT    = 3'd6;
  localparam logic [2:0] PORT_RES5     = 3'd7;

  // Commands
  localparam logic [7:0] CMD_ACK        = 8'h00;
  localparam logic [7:0] CMD_READ       = 8'h43;
  localparam logic [7:0] CMD_READ_RETRY = 8'h53;
  localparam logic [7:0] CMD_WRITE      = 8'h42;
  localparam logic [7:0] CMD_WRITE_ALT  = 8'h52;

  // Disk request codes
  typedef enum logic [1:0] {
    DREQ_NONE  = 2'd0,
    DREQ_READ  = 2'd1,
    DREQ_WRITE = 2'd2
  } dreq_t;

  // Status bits and status words
  localparam int         ST_XFER_BIT       = 2;
  localparam int         ST_READDIR_BIT    = 1;
  localparam logic [7:0] STATUS_DONE       = 8'h41;
  localparam logic [7:0] STATUS_ACK        = 8'h01;
  localparam logic [7:0] STATUS_BUSY       = 8'h09;
  localparam logic [7:0] STATUS_WRITE_XFER = 8'h05;
  localparam logic [7:0] STATUS_READ_XFER  = 8'h07;
  localparam logic [7:0] STATUS_REJECT     = 8'h81;

  // Result register values after reset; only the first one ever changes
  localparam logic [7:0] RES0_RESET = 8'h16;
  localparam logic [7:0] RES1       = 8'hAA;
  localparam logic [7:0] RES2       = 8'h55;
  localparam logic [7:0] RES3       = 8'hF0;
  localparam logic [7:0] RES4       = 8'h0F;
  localparam logic [7:0] RES5       = 8'h00;

  // Masks on parameter bytes
  localparam logic [7:0] COUNT_KEEP_MASK = 8'h80;

  // Disk transfer phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_FILL  = 3'b010,
    PH_DRAIN = 3'b100
  } phase_t;

  // One accepted input item
  typedef struct packed {
    logic [1:0]        req_type;
    logic [2:0]        port;
    logic [BYTE_W-1:0] host_wdata;
    logic [BYTE_W-1:0] disk_rdata;
  } in_item_t;

  // Item in flight between the control stage and the output stage
  typedef struct packed {
    logic [BYTE_W-1:0] host_rdata;
    logic              ram_to_host;
    logic              ram_to_disk;
    dreq_t             disk_request;
    logic [TRK_W-1:0]  trk;
    logic [SEC_W-1:0]  sec;
    logic [1:0]        count;
    logic              last;
  } s1_item_t;

endpackage

FILE: src/sdc_in_if.sv
// Input channel of the disk controller ports: valid/ready plus one item.
// Depends on sdc_pkg for field widths.
interface sdc_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [2:0]                port;
  logic [sdc_pkg::BYTE_W-1:0] host_wdata;
  logic [sdc_pkg::BYTE_W-1:0] disk_rdata;

  modport source (output valid, req_type, port, host_wdata, disk_rdata, input ready);
  modport sink   (input valid, req_type, port, host_wdata, disk_rdata, output ready);
endinterface

FILE: src/sdc_out_if.sv
// Result channel of the disk controller ports: valid/ready plus one result.
// Depends on sdc_pkg for field widths.
interface sdc_out_if;
  logic                              valid;
  logic                              ready;
  logic [sdc_pkg::BYTE_W-1:0]         host_rdata;
  logic [1:0]                        disk_request;
  logic [sdc_pkg::SECTOR_INDEX_W-1:0] disk_sector_index;
  logic [1:0]                        disk_sector_count;
  logic [sdc_pkg::BYTE_W-1:0]         disk_wdata;
  logic                              disk_last;

  modport source (output valid, host_rdata, disk_request, disk_sector_index,
                  disk_sector_count, disk_wdata, disk_last, input ready);
  modport sink   (input valid, host_rdata, disk_request, disk_sector_index,
                  disk_sector_count, disk_wdata, disk_last, output ready);
endinterface

FILE: src/sdc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/sdc_ctrl.sv
// Control stage: port registers, status, buffer pointers and disk phase;
// issues sector buffer reads and writes. Depends on sdc_pkg.
module sdc_ctrl #(
  parameter int BUFFER_BYTES      = 1024,
  parameter int SECTOR_BYTES      = 512,
  parameter int HEADS             = 4,
  parameter int MAX_SECTORS       = 2,
  localparam int PTR_W            = $clog2(BUFFER_BYTES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   acc,
  input  sdc_pkg::in_item_t      item,
  output sdc_pkg::s1_item_t      s1_item,
  output logic                   ram_we,
  output logic [PTR_W-1:0]       ram_waddr,
  output logic [sdc_pkg::BYTE_W-1:0] ram_wdata,
  output logic                   ram_re,
  output logic [PTR_W-1:0]       ram_raddr
);
  import sdc_pkg::*;

  localparam int LEFT_W = $clog2(MAX_SECTORS * SECTOR_BYTES + 1);
  localparam int NEED_W = COUNT_W + $clog2(SECTOR_BYTES + 1);
  localparam int HELD_W = PTR_W + 1;

  logic              drive_ready_r;
  logic [PTR_W-1:0]  rp_r, rp_nxt, wp_r, wp_nxt;
  logic              has_data_r, has_data_nxt;
  logic [7:0]        p3_r, p3_nxt, p4_r, p4_nxt, p5_r, p5_nxt, p6_r, p6_nxt;
  logic [7:0]        status_r, status_nxt;
  logic [7:0]        res0_r, res0_nxt;
  phase_t            phase_r, phase_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt, left_dec;

  logic [PTR_W-1:0]   rp_inc, wp_inc;
  logic [HELD_W-1:0]  held;
  logic [COUNT_W-1:0] count;
  logic [NEED_W-1:0]  need;
  logic               count_ok;
  logic [TRK_W-1:0]   trk;
  logic               do_we, do_re;

  // Advance a buffer pointer with wrap
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(BUFFER_BYTES - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Result registers by port; all but the first are fixed
  function automatic logic [7:0] result_byte(input logic [2:0] port,
                                             input logic [7:0] res0);
    logic [7:0] r;
    case (port)
      PORT_RES0:     r = res0;
      PORT_HEAD_CYL: r = RES1;
      PORT_CYL_LO:   r = RES2;
      PORT_SECTOR:   r = RES3;
      PORT_COUNT:    r = RES4;
      PORT_RES5:     r = RES5;
      default:       r = '0;
    endcase
    return r;
  endfunction

  // Derived values of the current state
  always_comb begin
    rp_inc   = next_ptr(rp_r);
    wp_inc   = next_ptr(wp_r);
    count    = p6_r[COUNT_W-1:0];
    need     = NEED_W'(count) * NEED_W'(SECTOR_BYTES);
    count_ok = (count != '0) && (count <= COUNT_W'(MAX_SECTORS));
    trk      = TRK_W'({3'b000, p3_r[3:0], p4_r} * TRK_W'(HEADS)) + TRK_W'(p3_r[6:4]);
    left_dec = (left_r != '0) ? (left_r - LEFT_W'(1)) : left_r;
    // bytes held after a host write at the write pointer
    if (wp_inc >= rp_r) begin
      held = HELD_W'(wp_inc) - HELD_W'(rp_r);
    end else begin
      held = HELD_W'(wp_inc) + HELD_W'(BUFFER_BYTES) - HELD_W'(rp_r);
    end
    if (held == '0) begin
      held = HELD_W'(BUFFER_BYTES);
    end
  end

  // Next state and item result for one accepted item
  always_comb begin
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    has_data_nxt = has_data_r;
    p3_nxt       = p3_r;
    p4_nxt       = p4_r;
    p5_nxt       = p5_r;
    p6_nxt       = p6_r;
    status_nxt   = status_r;
    res0_nxt     = res0_r;
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    s1_item      = '0;
    do_we        = 1'b0;
    do_re        = 1'b0;
    ram_wdata    = item.disk_rdata;

    case (item.req_type)
      REQ_HOST_RD: begin
        if (item.port == PORT_CMD) begin
          s1_item.host_rdata = status_r;
        end else if (item.port == PORT_DATA) begin
          if (has_data_r && status_r[ST_XFER_BIT] && status_r[ST_READDIR_BIT]) begin
            s1_item.ram_to_host = 1'b1;
            do_re  = 1'b1;
            rp_nxt = rp_inc;
            if (rp_inc == wp_r) begin
              has_data_nxt = 1'b0;
              status_nxt   = STATUS_DONE;
              res0_nxt     = '0;
            end
          end
        end else begin
          s1_item.host_rdata = result_byte(item.port, res0_r);
        end
      end

      REQ_HOST_WR: begin
        case (item.port)
          PORT_HEAD_CYL: p3_nxt = item.host_wdata;
          PORT_CYL_LO:   p4_nxt = item.host_wdata;
          PORT_SECTOR:   p5_nxt = item.host_wdata;
          PORT_COUNT:    p6_nxt = item.host_wdata;
          default:       ;
        endcase
        if (item.port == PORT_DATA) begin
          if (status_r[ST_XFER_BIT] && !status_r[ST_READDIR_BIT]) begin
            // store the byte; issue the disk write once enough is held
            do_we     = 1'b1;
            ram_wdata = item.host_wdata;
            wp_nxt    = wp_inc;
            if (count_ok && (NEED_W'(held) == need)) begin
              s1_item.disk_request = DREQ_WRITE;
              s1_item.trk          = trk;
              s1_item.sec          = p5_r[SEC_W-1:0];
              s1_item.count        = count[1:0];
              phase_nxt            = PH_DRAIN;
              left_nxt             = LEFT_W'(need);
              status_nxt           = STATUS_BUSY;
            end
          end
        end else if (item.port == PORT_CMD) begin
          if (item.host_wdata == CMD_ACK) begin
            status_nxt = STATUS_ACK;
          end else if (item.host_wdata == CMD_READ || item.host_wdata == CMD_READ_RETRY) begin
            if (drive_ready_r && (count <= COUNT_W'(MAX_SECTORS))) begin
              phase_nxt    = PH_IDLE;
              rp_nxt       = '0;
              wp_nxt       = '0;
              has_data_nxt = 1'b0;
              p6_nxt       = p6_r & COUNT_KEEP_MASK;
              if (count == '0) begin
                status_nxt = STATUS_DONE;
                res0_nxt   = '0;
              end else begin
                s1_item.disk_request = DREQ_READ;
                s1_item.trk          = trk;
                s1_item.sec          = p5_r[SEC_W-1:0];
                s1_item.count        = count[1:0];
                phase_nxt            = PH_FILL;
                left_nxt             = LEFT_W'(need);
                status_nxt           = STATUS_BUSY;
              end
            end
          end else if (item.host_wdata == CMD_WRITE || item.host_wdata == CMD_WRITE_ALT) begin
            phase_nxt    = PH_IDLE;
            rp_nxt       = '0;
            wp_nxt       = '0;
            has_data_nxt = 1'b0;
            status_nxt   = STATUS_WRITE_XFER;
          end else begin
            status_nxt = STATUS_REJECT;
          end
        end
      end

      REQ_DISK_FILL: begin
        if (phase_r == PH_FILL) begin
          do_we    = 1'b1;
          wp_nxt   = wp_inc;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            has_data_nxt = 1'b1;
            status_nxt   = STATUS_READ_XFER;
            phase_nxt    = PH_IDLE;
            s1_item.last = 1'b1;
          end
        end
      end

      REQ_DISK_PULL: begin
        if (phase_r == PH_DRAIN) begin
          s1_item.ram_to_disk = 1'b1;
          do_re    = 1'b1;
          rp_nxt   = rp_inc;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            has_data_nxt = 1'b0;
            status_nxt   = STATUS_DONE;
            res0_nxt     = '0;
            p6_nxt       = p6_r & COUNT_KEEP_MASK;
            phase_nxt    = PH_IDLE;
            s1_item.last = 1'b1;
          end
        end
      end

      default: ;
    endcase
  end

  // Buffer access at the transfer edge
  assign ram_we    = acc && do_we;
  assign ram_re    = acc && do_re;
  assign ram_waddr = wp_r;
  assign ram_raddr = rp_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_ready_r <= 1'b0;
    end else if (cfg_we) begin
      drive_ready_r <= cfg_wdata;
    end
  end

  // Control state, updated on every transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r       <= '0;
      wp_r       <= '0;
      has_data_r <= 1'b0;
      p3_r       <= '0;
      p4_r       <= '0;
      p5_r       <= '0;
      p6_r       <= '0;
      status_r   <= STATUS_DONE;
      res0_r     <= RES0_RESET;
      phase_r    <= PH_IDLE;
      left_r     <= '0;
    end else if (acc) begin
      rp_r       <= rp_nxt;
      wp_r       <= wp_nxt;
      has_data_r <= has_data_nxt;
      p3_r       <= p3_nxt;
      p4_r       <= p4_nxt;
      p5_r       <= p5_nxt;
      p6_r       <= p6_nxt;
      status_r   <= status_nxt;
      res0_r     <= res0_nxt;
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
    end
  end

`ifndef SYNTHESIS
  // An active disk transfer always has bytes left
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (left_r != '0))
    else $error("disk phase active with no bytes left");

  // Read data waiting for the host only exists outside a disk transfer
  a_data_idle: assert property (@(posedge clk) disable iff (!rst_n)
    has_data_r |-> (phase_r == PH_IDLE))
    else $error("buffer data flagged during disk transfer");

  // One item never both reads and writes the buffer
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("buffer read and write from one item");
`endif

endmodule

FILE: src/sdc_out_stage.sv
// Output stage: merges buffer read data, finishes the sector index and
// holds the result register. Depends on sdc_pkg.
module sdc_out_stage #(
  parameter int SECTORS_PER_TRACK = 22
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s1_load,
  input  sdc_pkg::s1_item_t          s1_item,
  input  logic [sdc_pkg::BYTE_W-1:0] ram_rdata,
  output logic                       s1_ready,
  sdc_out_if.source                  out_chan
);
  import sdc_pkg::*;

  localparam int PROD_W = TRK_W + SEC_W;

  logic                      s1_v_r;
  s1_item_t                  s1_r;
  logic                      out_v_r;
  logic [BYTE_W-1:0]         host_rdata_r, host_rdata_nxt;
  dreq_t                     dreq_r;
  logic [SECTOR_INDEX_W-1:0] index_r, index_nxt;
  logic [1:0]                count_r;
  logic [BYTE_W-1:0]         wdata_r, wdata_nxt;
  logic                      last_r;
  logic                      advance;
  logic [PROD_W-1:0]         prod;

  assign advance  = s1_v_r && (!out_v_r || out_chan.ready);
  assign s1_ready = !s1_v_r || !out_v_r || out_chan.ready;

  // Linear sector from track and sector
  always_comb begin
    prod           = PROD_W'(s1_r.trk) * PROD_W'(SECTORS_PER_TRACK) + PROD_W'(s1_r.sec);
    index_nxt      = prod[SECTOR_INDEX_W-1:0];
    host_rdata_nxt = s1_r.ram_to_host ? ram_rdata : s1_r.host_rdata;
    wdata_nxt      = s1_r.ram_to_disk ? ram_rdata : '0;
  end

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_r <= 1'b1;
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= s1_item;
    end
    if (advance) begin
      host_rdata_r <= host_rdata_nxt;
      dreq_r       <= s1_r.disk_request;
      index_r      <= index_nxt;
      count_r      <= s1_r.count;
      wdata_r      <= wdata_nxt;
      last_r       <= s1_r.last;
    end
  end

  assign out_chan.valid             = out_v_r;
  assign out_chan.host_rdata        = host_rdata_r;
  assign out_chan.disk_request      = dreq_r;
  assign out_chan.disk_sector_index = index_r;
  assign out_chan.disk_sector_count = count_r;
  assign out_chan.disk_wdata        = wdata_r;
  assign out_chan.disk_last         = last_r;

`ifndef SYNTHESIS
  // A loaded item is held in the stage on the next cycle
  a_load_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> s1_v_r)
    else $error("accepted item lost from stage one");

  // No item is loaded into a full stage that cannot drain
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_chan.ready) |-> !s1_load)
    else $error("stage one overwritten while stalled");
`endif

endmodule

FILE: src/smart_disk_controller_ports_unit.sv
// Top level of the disk controller host ports: control stage, sector
// buffer RAM and output stage. Depends on sdc_pkg, sdc_in_if, sdc_out_if,
// sdc_ram, sdc_ctrl and sdc_out_stage.
//
// Usage: every input transfer on in_chan is one host port read, one host
// port write, one disk fill byte or one disk pull byte. Each produces
// exactly one result transfer on out_chan, in order. cfg_we/cfg_wdata set
// the drive-ready flag; write it only while no item is in flight.
// An item is registered in stage one and then in the output register.
// Throughput: one item per cycle while the receiver does not stall. State
// updates happen at the input transfer and the sector buffer (one write
// port, one registered read port) is touched at most once per item, so
// items follow back to back. A stalled receiver fills the output register
// and then stage one; input ready drops only when both hold results.
// Synchronous reset clears the pointers, sets the phase idle, the status to
// 0x41 and res0 to 0x16; the buffer stays undefined until written, with no clearing pass.
module smart_disk_controller_ports_unit #(
  parameter int BUFFER_BYTES      = 1024,
  parameter int SECTOR_BYTES      = 512,
  parameter int HEADS             = 4,
  parameter int SECTORS_PER_TRACK = 22,
  parameter int MAX_SECTORS       = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  sdc_in_if.sink    in_chan,
  sdc_out_if.source out_chan
);
  import sdc_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_BYTES);

  logic              acc;
  logic              s1_ready;
  in_item_t          item;
  s1_item_t          s1_item;
  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  // Input transfer
  assign in_chan.ready   = s1_ready;
  assign acc             = in_chan.valid && s1_ready;
  assign item.req_type   = in_chan.req_type;
  assign item.port       = in_chan.port;
  assign item.host_wdata = in_chan.host_wdata;
  assign item.disk_rdata = in_chan.disk_rdata;

  sdc_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .HEADS        (HEADS),
    .MAX_SECTORS  (MAX_SECTORS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .item      (item),
    .s1_item   (s1_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  sdc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sdc_out_stage #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_load   (acc),
    .s1_item   (s1_item),
    .ram_rdata (ram_rdata),
    .s1_ready  (s1_ready),
    .out_chan  (out_chan)
  );

endmodule
